// ----- hw/rtl/lssg_pkg.sv -----
// Shared types, widths, register indexes and table generators for the log sine sweep generator.
// No dependencies; every other file of the block refers to this package by scoped names.
package lssg_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned EXP_TABLE_BITS  = 8;

  localparam int unsigned LOG_W    = 25;
  localparam int unsigned FRAC_W   = 20;
  localparam int unsigned INT_W    = LOG_W - FRAC_W;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MANT_W   = 32;
  localparam int unsigned QUOT_W   = LOG_W;
  localparam int unsigned DIVD_W   = LEN_W + QUOT_W;
  localparam int unsigned STEP_W   = $clog2(QUOT_W);
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CFG_W    = 32;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [MANT_W-1:0] INC_MAX = 32'h7FFF_FFFF;

  localparam logic [IDX_W-1:0] REG_LOG_START = 8'd0;
  localparam logic [IDX_W-1:0] REG_LOG_END   = 8'd1;
  localparam logic [IDX_W-1:0] REG_LENGTH    = 8'd2;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE = 8'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LOG,
    S_EXP,
    S_INTERP,
    S_MANT,
    S_INC,
    S_DONE
  } lssg_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } lssg_div_ctrl_t;

  typedef struct packed {
    logic lookup;
    logic interp;
    logic mant;
  } lssg_exp_ctrl_t;

  typedef struct packed {
    logic look;
    logic scale;
  } lssg_sine_ctrl_t;

  // 2^(k / 2^bits) in Q1.30 from a truncated exp series
  function automatic logic [63:0] exp_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = (64'(k) * LN2_Q30) >> bits;
    term = y;
    sum  = ONE_Q30 + y;
    for (int n = 2; n <= 16; n++) begin
      term = ((term * y) >> 30) / 64'(n);
      sum  = sum + term;
    end
    return sum;
  endfunction

  // sin of r quarter-table steps, rounded to Q1.15
  function automatic logic [15:0] quarter_sine(input int unsigned r, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] res;
    x    = (64'(r) * HALF_PI_Q30) >> (bits - 2);
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    if (neg >= pos) begin
      res = 64'd0;
    end else begin
      res = ((pos - neg) * 64'd32767 + (64'd1 << 29)) >> 30;
    end
    return res[15:0];
  endfunction

endpackage

// ----- hw/rtl/lssg_div.sv -----
// Restoring divider: one quotient bit per step, quotient known to fit QUOT_W bits.
// Depends on lssg_pkg.
module lssg_div (
  input  logic                          clk_i,
  input  lssg_pkg::lssg_div_ctrl_t      ctrl_i,
  input  logic [lssg_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [lssg_pkg::LEN_W-1:0]    divisor_i,
  output logic [lssg_pkg::QUOT_W-1:0]   quotient_o
);

  logic [lssg_pkg::LEN_W-1:0]  rem_q;
  logic [lssg_pkg::QUOT_W-1:0] lo_q;
  logic [lssg_pkg::LEN_W:0]    trial;
  logic [lssg_pkg::LEN_W:0]    diff;
  logic                        ge;

  assign trial = {rem_q, lo_q[lssg_pkg::QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= dividend_i[lssg_pkg::DIVD_W-1:lssg_pkg::QUOT_W];
      lo_q  <= dividend_i[lssg_pkg::QUOT_W-1:0];
    end else if (ctrl_i.step) begin
      rem_q <= ge ? diff[lssg_pkg::LEN_W-1:0] : trial[lssg_pkg::LEN_W-1:0];
      lo_q  <= {lo_q[lssg_pkg::QUOT_W-2:0], ge};
    end
  end

  assign quotient_o = lo_q;

endmodule

// ----- hw/rtl/lssg_exp.sv -----
// Log-to-linear converter: 2^x table lookup, linear interpolation, shift and saturate.
// Depends on lssg_pkg for widths and the table generator.
module lssg_exp #(
  parameter int unsigned EXP_TABLE_BITS = lssg_pkg::EXP_TABLE_BITS
) (
  input  logic                          clk_i,
  input  lssg_pkg::lssg_exp_ctrl_t      ctrl_i,
  input  logic [lssg_pkg::LOG_W-1:0]    logv_i,
  output logic [lssg_pkg::MANT_W-1:0]   inc_o
);

  localparam int unsigned RW = lssg_pkg::FRAC_W - EXP_TABLE_BITS;
  localparam int unsigned NE = (2 ** EXP_TABLE_BITS) + 1;
  localparam int unsigned PW = lssg_pkg::MANT_W + RW;

  logic [lssg_pkg::MANT_W-1:0] exp_tab [NE];

  for (genvar g = 0; g < NE; g++) begin : g_exp
    localparam logic [63:0] EV = lssg_pkg::exp_entry(g, EXP_TABLE_BITS);
    assign exp_tab[g] = EV[lssg_pkg::MANT_W-1:0];
  end

  logic [EXP_TABLE_BITS:0]      k0;
  logic [EXP_TABLE_BITS:0]      k1;
  logic [lssg_pkg::MANT_W-1:0]  e0_q;
  logic [lssg_pkg::MANT_W-1:0]  e1_q;
  logic [RW-1:0]                r_q;
  logic [lssg_pkg::INT_W-1:0]   ip_q;
  logic [PW-1:0]                dp_q;
  logic [lssg_pkg::MANT_W-1:0]  m_q;
  logic [lssg_pkg::MANT_W-1:0]  ediff;
  logic [PW-1:0]                dp_shr;
  logic [lssg_pkg::INT_W-1:0]   shamt;
  logic [lssg_pkg::MANT_W-1:0]  shifted;

  assign k0    = {1'b0, logv_i[lssg_pkg::FRAC_W-1 -: EXP_TABLE_BITS]};
  assign k1    = k0 + (EXP_TABLE_BITS + 1)'(1);
  assign ediff = e1_q - e0_q;
  assign dp_shr = dp_q >> RW;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lookup) begin
      e0_q <= exp_tab[k0];
      e1_q <= exp_tab[k1];
      r_q  <= logv_i[RW-1:0];
      ip_q <= logv_i[lssg_pkg::LOG_W-1:lssg_pkg::FRAC_W];
    end
    if (ctrl_i.interp) begin
      dp_q <= PW'(ediff) * PW'(r_q);
    end
    if (ctrl_i.mant) begin
      m_q <= e0_q + dp_shr[lssg_pkg::MANT_W-1:0];
    end
  end

  assign shamt   = lssg_pkg::INT_W'(30) - ip_q;
  assign shifted = m_q >> shamt;

  always_comb begin
    if (ip_q == {lssg_pkg::INT_W{1'b1}}) begin
      inc_o = lssg_pkg::INC_MAX;
    end else if (shifted > lssg_pkg::INC_MAX) begin
      inc_o = lssg_pkg::INC_MAX;
    end else begin
      inc_o = shifted;
    end
  end

endmodule

// ----- hw/rtl/lssg_sine.sv -----
// Sine table lookup by quarter-wave symmetry and amplitude scaling with rounding.
// Depends on lssg_pkg for widths and the table generator.
module lssg_sine #(
  parameter int unsigned SINE_TABLE_BITS = lssg_pkg::SINE_TABLE_BITS
) (
  input  logic                            clk_i,
  input  lssg_pkg::lssg_sine_ctrl_t       ctrl_i,
  input  logic [lssg_pkg::PHASE_W-1:0]    phase_i,
  input  logic [lssg_pkg::AMP_W-1:0]      amplitude_i,
  output logic [lssg_pkg::SAMPLE_W-1:0]   sample_o
);

  localparam int unsigned QB = SINE_TABLE_BITS - 2;
  localparam int unsigned QN = 2 ** QB;
  localparam int unsigned PRW = 32;

  logic [15:0] sine_tab [QN + 1];

  for (genvar g = 0; g <= QN; g++) begin : g_sine
    localparam logic [15:0] SV = lssg_pkg::quarter_sine(g, SINE_TABLE_BITS);
    assign sine_tab[g] = SV;
  end

  logic [SINE_TABLE_BITS-1:0]    idx;
  logic [QB:0]                   ta;
  logic [15:0]                   s_q;
  logic                          neg_q;
  logic [PRW-1:0]                prod;
  logic [lssg_pkg::SAMPLE_W-1:0] mag;
  logic [lssg_pkg::SAMPLE_W-1:0] sample_q;

  assign idx = phase_i[lssg_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
  assign ta  = idx[QB] ? ((QB + 1)'(QN) - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
  assign prod = PRW'(amplitude_i) * PRW'(s_q) + PRW'(16384);
  assign mag  = prod[15 +: lssg_pkg::SAMPLE_W];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.look) begin
      s_q   <= sine_tab[ta];
      neg_q <= idx[SINE_TABLE_BITS-1];
    end
    if (ctrl_i.scale) begin
      sample_q <= neg_q ? (lssg_pkg::SAMPLE_W'(0) - mag) : mag;
    end
  end

  assign sample_o = sample_q;

endmodule

// ----- hw/rtl/log_sine_sweep_generator_top.sv -----
// Log sine sweep generator top level: configuration registers, sweep state and sequencer.
// Depends on lssg_pkg, lssg_div, lssg_exp and lssg_sine.
//
// Each input transfer yields one output transfer carrying a sample of an exponential sine
// sweep. An active sample first looks up the sine and multiplies the log-increment span
// by the sample counter, then passes the restoring divider (one quotient bit per cycle),
// then scaling, the 2^x table, interpolation, the mantissa, the shift with saturation and
// the output register. Once the sweep is over, or with a zero sweep length, the result
// goes from the lookup straight to the output register. The input is ready again once
// the result is registered; a result still waiting for the receiver holds the sequencer
// until it leaves. One item is in flight at a time; a finished result waits in the
// output register, so the next item is taken while it is pending. The configuration port
// is always ready; it is to be written only while no item is in flight, and the block
// itself does not enforce this.
module log_sine_sweep_generator_top #(
  parameter int unsigned SINE_TABLE_BITS = lssg_pkg::SINE_TABLE_BITS,
  parameter int unsigned EXP_TABLE_BITS  = lssg_pkg::EXP_TABLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lssg_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [lssg_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [0] restart
  input  logic                           s_axis_tlast,   // block_end
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,   // [15:0] sample_value
  output logic [0:0]                     m_axis_tuser,   // [0] sweep_active
  output logic                           m_axis_tlast    // block_last
);

  lssg_pkg::lssg_state_e state_q, state_d;

  logic [lssg_pkg::LOG_W-1:0]    start_q;
  logic [lssg_pkg::LOG_W-1:0]    end_q;
  logic [lssg_pkg::LEN_W-1:0]    len_q;
  logic [lssg_pkg::AMP_W-1:0]    amp_q;

  logic [lssg_pkg::PHASE_W-1:0]  phase_q;
  logic [lssg_pkg::LEN_W-1:0]    cnt_q;
  logic [lssg_pkg::MANT_W-1:0]   inc_q;

  logic [lssg_pkg::QUOT_W-1:0]   diff_q;
  logic                          down_q;
  logic                          last_q;
  logic                          active_q;
  logic [lssg_pkg::STEP_W-1:0]   step_q;
  logic [lssg_pkg::LOG_W-1:0]    logv_q;

  logic                          out_valid_q;
  logic [lssg_pkg::SAMPLE_W-1:0] out_sample_q;
  logic                          out_active_q;
  logic                          out_last_q;

  logic                          in_xfer;
  logic                          out_free;
  logic                          active;
  logic [lssg_pkg::DIVD_W-1:0]   dividend;
  logic [lssg_pkg::QUOT_W-1:0]   quotient;
  logic [lssg_pkg::MANT_W-1:0]   inc_new;
  logic [lssg_pkg::SAMPLE_W-1:0] sample;

  lssg_pkg::lssg_div_ctrl_t  div_ctrl;
  lssg_pkg::lssg_exp_ctrl_t  exp_ctrl;
  lssg_pkg::lssg_sine_ctrl_t sine_ctrl;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == lssg_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign active        = cnt_q < len_q;
  assign dividend      = lssg_pkg::DIVD_W'(diff_q) * lssg_pkg::DIVD_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      len_q   <= '0;
      amp_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lssg_pkg::REG_LOG_START: start_q <= cfg_data_i[lssg_pkg::LOG_W-1:0];
        lssg_pkg::REG_LOG_END:   end_q   <= cfg_data_i[lssg_pkg::LOG_W-1:0];
        lssg_pkg::REG_LENGTH:    len_q   <= cfg_data_i[lssg_pkg::LEN_W-1:0];
        lssg_pkg::REG_AMPLITUDE: amp_q   <= cfg_data_i[lssg_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lssg_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_ctrl  = '0;
    exp_ctrl  = '0;
    sine_ctrl = '0;
    case (state_q)
      lssg_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_d = lssg_pkg::S_MUL;
        end
      end
      lssg_pkg::S_MUL: begin
        div_ctrl.load  = 1'b1;
        sine_ctrl.look = 1'b1;
        state_d = active ? lssg_pkg::S_DIV : lssg_pkg::S_DONE;
      end
      lssg_pkg::S_DIV: begin
        div_ctrl.step = 1'b1;
        if (step_q == lssg_pkg::STEP_W'(lssg_pkg::QUOT_W - 1)) begin
          state_d = lssg_pkg::S_LOG;
        end
      end
      lssg_pkg::S_LOG: begin
        sine_ctrl.scale = 1'b1;
        state_d = lssg_pkg::S_EXP;
      end
      lssg_pkg::S_EXP: begin
        exp_ctrl.lookup = 1'b1;
        state_d = lssg_pkg::S_INTERP;
      end
      lssg_pkg::S_INTERP: begin
        exp_ctrl.interp = 1'b1;
        state_d = lssg_pkg::S_MANT;
      end
      lssg_pkg::S_MANT: begin
        exp_ctrl.mant = 1'b1;
        state_d = lssg_pkg::S_INC;
      end
      lssg_pkg::S_INC: begin
        state_d = lssg_pkg::S_DONE;
      end
      lssg_pkg::S_DONE: begin
        if (out_free) begin
          state_d = lssg_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lssg_pkg::S_IDLE;
      end
    endcase
  end

  // sweep state: clear on restart, take the new increment, advance once an active sample is registered for output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cnt_q   <= '0;
      inc_q   <= '0;
    end else if (in_xfer && s_axis_tdata[0]) begin
      phase_q <= '0;
      cnt_q   <= '0;
      inc_q   <= '0;
    end else if (state_q == lssg_pkg::S_INC) begin
      inc_q <= inc_new;
    end else if (state_q == lssg_pkg::S_DONE && out_free && active_q) begin
      phase_q <= phase_q + inc_q;
      cnt_q   <= cnt_q + lssg_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == lssg_pkg::S_MUL) begin
      step_q <= '0;
    end else if (state_q == lssg_pkg::S_DIV) begin
      step_q <= step_q + lssg_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      last_q <= s_axis_tlast;
      down_q <= end_q < start_q;
      diff_q <= (end_q < start_q) ? (start_q - end_q) : (end_q - start_q);
    end
    if (state_q == lssg_pkg::S_MUL) begin
      active_q <= active;
    end
    if (state_q == lssg_pkg::S_LOG) begin
      logv_q <= down_q ? (start_q - quotient) : (start_q + quotient);
    end
  end

  lssg_div u_div (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (len_q),
    .quotient_o (quotient)
  );

  lssg_exp #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_exp (
    .clk_i  (clk_i),
    .ctrl_i (exp_ctrl),
    .logv_i (logv_q),
    .inc_o  (inc_new)
  );

  lssg_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk_i       (clk_i),
    .ctrl_i      (sine_ctrl),
    .phase_i     (phase_q),
    .amplitude_i (amp_q),
    .sample_o    (sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lssg_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lssg_pkg::S_DONE && out_free) begin
      out_sample_q <= active_q ? sample : '0;
      out_active_q <= active_q;
      out_last_q   <= last_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_sample_q;
  assign m_axis_tuser[0] = out_active_q;
  assign m_axis_tlast    = out_last_q;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for log_sine_sweep_generator_top: drives sample ticks and register
// writes, predicts each sweep sample and compares it with the output stream.
// Depends on lssg_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SIN_BITS    = lssg_pkg::SINE_TABLE_BITS;
  localparam int unsigned EXP_BITS    = lssg_pkg::EXP_TABLE_BITS;
  localparam int unsigned FRAC_BITS   = lssg_pkg::FRAC_W;
  localparam int unsigned QUARTER     = 1 << (SIN_BITS - 2);
  localparam int unsigned EXP_ENTRIES = 1 << EXP_BITS;
  localparam int unsigned RAND_ITEMS  = 1500;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic restart;
    logic block_end;
  } sweep_tick_t;

  typedef struct packed {
    logic [15:0] value;
    logic        active;
    logic        last;
  } sweep_sample_t;

  typedef struct packed {
    logic [lssg_pkg::IDX_W-1:0] index;
    logic [lssg_pkg::CFG_W-1:0] data;
  } reg_write_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [lssg_pkg::IDX_W-1:0] cfg_index_i = '0;
  logic [lssg_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata = '0;
  logic                       s_axis_tlast = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [15:0]                m_axis_tdata;
  logic [0:0]                 m_axis_tuser;
  logic                       m_axis_tlast;

  log_sine_sweep_generator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sweep_tick_t   tick_q[$];
  reg_write_t    reg_write_q[$];
  sweep_sample_t sample_q[$];

  int unsigned ticks_sent, ticks_taken, writes_sent, writes_taken;
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned err_cnt, checked_cnt, active_cnt, restart_cnt, setting_cnt, cycle_cnt;

  // predictor copy of registers and sweep state
  logic [24:0] log_start, log_end;
  logic [31:0] sweep_len;
  logic [14:0] amp_gain;
  logic [31:0] phase_acc, samp_cnt, cur_inc;

  logic [63:0] pow2_tab [0:EXP_ENTRIES];
  logic [15:0] sin_tab  [0:QUARTER];

  function automatic logic [63:0] pow2_frac_q30(input int unsigned k);
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] acc;
    y   = (64'(k) * lssg_pkg::LN2_Q30) >> EXP_BITS;
    t   = y;
    acc = lssg_pkg::ONE_Q30 + y;
    for (int n = 2; n <= 16; n++) begin
      t   = ((t * y) >> 30) / 64'(n);
      acc = acc + t;
    end
    return acc;
  endfunction

  function automatic logic [15:0] quarter_sin_q15(input int unsigned step);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] up;
    logic [63:0] dn;
    x  = (64'(step) * lssg_pkg::HALF_PI_Q30) >> (SIN_BITS - 2);
    t  = x;
    up = x;
    dn = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      t = ((((t * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        dn = dn + t;
      end else begin
        up = up + t;
      end
    end
    if (dn >= up) begin
      return 16'd0;
    end
    return 16'((((up - dn) * 64'd32767) + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic [31:0] phase_step(input logic [24:0] lg);
    int unsigned ip;
    int unsigned k;
    int unsigned r;
    logic [63:0] m;
    logic [63:0] inc;
    ip  = lg >> FRAC_BITS;
    k   = (lg & ((1 << FRAC_BITS) - 1)) >> (FRAC_BITS - EXP_BITS);
    r   = lg & ((1 << (FRAC_BITS - EXP_BITS)) - 1);
    m   = pow2_tab[k] + (((pow2_tab[k + 1] - pow2_tab[k]) * 64'(r)) >> (FRAC_BITS - EXP_BITS));
    inc = (ip >= 30) ? (m << (ip - 30)) : (m >> (30 - ip));
    if (inc > 64'(lssg_pkg::INC_MAX)) begin
      inc = 64'(lssg_pkg::INC_MAX);
    end
    return inc[31:0];
  endfunction

  function automatic sweep_sample_t predict_sample(input sweep_tick_t tk);
    sweep_sample_t o;
    logic [63:0]   span;
    logic [24:0]   lg;
    logic [63:0]   mag;
    logic [15:0]   s;
    int unsigned   idx;
    int unsigned   quad;
    int unsigned   r;
    if (tk.restart) begin
      phase_acc = '0;
      samp_cnt  = '0;
      cur_inc   = '0;
    end
    o.value  = '0;
    o.active = 1'b0;
    o.last   = tk.block_end;
    if (samp_cnt < sweep_len) begin
      if (log_end >= log_start) begin
        span = (64'(log_end - log_start) * 64'(samp_cnt)) / 64'(sweep_len);
        lg   = log_start + 25'(span);
      end else begin
        span = (64'(log_start - log_end) * 64'(samp_cnt)) / 64'(sweep_len);
        lg   = log_start - 25'(span);
      end
      cur_inc = phase_step(lg);
      idx  = phase_acc >> (32 - SIN_BITS);
      quad = idx >> (SIN_BITS - 2);
      r    = idx % QUARTER;
      s    = (quad % 2 == 1) ? sin_tab[QUARTER - r] : sin_tab[r];
      mag  = (64'(amp_gain) * 64'(s) + 64'd16384) >> 15;
      o.value  = (quad >= 2) ? 16'(64'h10000 - mag) : 16'(mag);
      o.active = 1'b1;
      phase_acc = phase_acc + cur_inc;
      samp_cnt  = samp_cnt + 32'd1;
    end
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      m_axis_tready <= 1'b0;
      cfg_valid_i   <= 1'b0;
      cfg_index_i   <= '0;
      cfg_data_i    <= '0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, tick_q[0].restart};
          s_axis_tlast  <= tick_q[0].block_end;
          void'(tick_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_write_q.size() != 0) begin
          cfg_valid_i <= 1'b1;
          cfg_index_i <= reg_write_q[0].index;
          cfg_data_i  <= reg_write_q[0].data;
          void'(reg_write_q.pop_front());
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    sweep_sample_t got;
    sweep_sample_t exp_s;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        writes_taken++;
        case (cfg_index_i)
          lssg_pkg::REG_LOG_START: log_start = cfg_data_i[24:0];
          lssg_pkg::REG_LOG_END:   log_end   = cfg_data_i[24:0];
          lssg_pkg::REG_LENGTH:    sweep_len = cfg_data_i;
          lssg_pkg::REG_AMPLITUDE: amp_gain  = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.value  = m_axis_tdata;
        got.active = m_axis_tuser[0];
        got.last   = m_axis_tlast;
        if (sample_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: unexpected transfer: got value %0d active %b last %b", $time,
                     $signed(got.value), got.active, got.last);
          end
        end else begin
          exp_s = sample_q.pop_front();
          checked_cnt++;
          if (exp_s.active) begin
            active_cnt++;
          end
          if (got.value !== exp_s.value || got.active !== exp_s.active ||
              got.last !== exp_s.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected value %0d active %b last %b, got value %0d active %b last %b",
                       $time, $signed(exp_s.value), exp_s.active, exp_s.last,
                       $signed(got.value), got.active, got.last);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ticks_taken++;
        sample_q.push_back(predict_sample({s_axis_tdata[0], s_axis_tlast}));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [lssg_pkg::IDX_W-1:0] index,
                           input logic [lssg_pkg::CFG_W-1:0] data);
    reg_write_q.push_back({index, data});
    writes_sent++;
  endtask

  task automatic wait_writes();
    while (writes_taken != writes_sent) @(posedge clk_i);
    setting_cnt++;
  endtask

  task automatic push_tick(input logic restart, input logic block_end);
    tick_q.push_back({restart, block_end});
    ticks_sent++;
    if (restart) begin
      restart_cnt++;
    end
  endtask

  task automatic settle();
    while (ticks_taken != ticks_sent || sample_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default: begin send_idle_pct = 9; recv_stall_pct = 9; end
    endcase
  endtask

  function automatic logic [31:0] pick_log();
    case ($urandom_range(7))
      0:       return {7'($urandom()), 25'h0};
      1:       return {7'($urandom()), 25'h1FF_FFFF};
      default: return {7'($urandom()), 25'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return $urandom();
      2:       return 32'd1;
      default: return $urandom_range(100, 2);
    endcase
  endfunction

  function automatic logic [31:0] pick_amp();
    case ($urandom_range(7))
      0:       return {17'($urandom()), 15'h0};
      1:       return {17'($urandom()), 15'h7FFF};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned rand_done;
    int unsigned run_len;
    int unsigned phase;
    for (int k = 0; k <= EXP_ENTRIES; k++) begin
      pow2_tab[k] = pow2_frac_q30(k);
    end
    for (int r = 0; r <= QUARTER; r++) begin
      sin_tab[r] = quarter_sin_q15(r);
    end
    log_start = '0;
    log_end   = '0;
    sweep_len = '0;
    amp_gain  = '0;
    phase_acc = '0;
    samp_cnt  = '0;
    cur_inc   = '0;
    set_idling(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: zero length, silence
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    settle();

    // saturated start sweeping down, oversized data, unknown indexes, sweep running out
    set_idling(1);
    write_reg(lssg_pkg::REG_LOG_START, 32'hFFFF_FFFF);
    write_reg(lssg_pkg::REG_LOG_END, 32'hFE00_0000);
    write_reg(lssg_pkg::REG_LENGTH, 32'd4);
    write_reg(lssg_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(8'd4, 32'd123);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    wait_writes();
    for (int i = 0; i < 6; i++) begin
      push_tick(1'b0, i[0]);
    end
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    settle();

    // longest sweep, high increments near saturation, full amplitude
    set_idling(2);
    write_reg(lssg_pkg::REG_LOG_START, 32'hAB_E00000 | 32'h01E0_0000);
    write_reg(lssg_pkg::REG_LOG_END, 32'h55FF_FFFF);
    write_reg(lssg_pkg::REG_LENGTH, 32'hFFFF_FFFF);
    write_reg(lssg_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
    wait_writes();
    push_tick(1'b1, 1'b0);
    for (int i = 0; i < 5; i++) begin
      push_tick(1'b0, (i == 4));
    end
    settle();

    // zero length after an active sweep
    set_idling(3);
    write_reg(lssg_pkg::REG_LENGTH, 32'd0);
    wait_writes();
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    settle();

    rand_done = 0;
    phase     = 0;
    while (rand_done < RAND_ITEMS) begin
      set_idling(phase);
      phase++;
      write_reg(lssg_pkg::REG_LOG_START, pick_log());
      write_reg(lssg_pkg::REG_LOG_END, pick_log());
      write_reg(lssg_pkg::REG_LENGTH, pick_length());
      write_reg(lssg_pkg::REG_AMPLITUDE, pick_amp());
      if ($urandom_range(3) == 0) begin
        write_reg(8'($urandom_range(255, 4)), $urandom());
      end
      wait_writes();
      run_len = $urandom_range(80, 20);
      for (int i = 0; i < run_len; i++) begin
        push_tick((i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(99) < 3),
                  ($urandom_range(3) == 0));
      end
      rand_done += run_len;
      settle();
    end

    $display("Sweep run: %0d samples checked (%0d active), %0d restarts, %0d register settings",
             checked_cnt, active_cnt, restart_cnt, setting_cnt);
    $display("Idling covered: none, sender gaps, receiver stalls and both; %0d cycles", cycle_cnt);
    if (err_cnt == 0 && sample_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lssg_pkg.sv
hw/rtl/lssg_div.sv
hw/rtl/lssg_exp.sv
hw/rtl/lssg_sine.sv
hw/rtl/log_sine_sweep_generator_top.sv
dv/tb_top.sv
